// ===== rtl/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types and constants of the lowest-timestamp safety check.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int unsigned TimeW = 48;
  localparam int unsigned CoreIdW = 4;
  localparam int unsigned ActiveW = 5;
  localparam int unsigned UpdW = 4;
  localparam int unsigned DefMaxCores = 16;

  localparam logic [TimeW-1:0] TIME_INF = '1;
  localparam logic [ActiveW-1:0] ACTIVE_RST = ActiveW'(16);
  localparam logic [UpdW-1:0] UPD_MAX = '1;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_COMMIT = 2'd1,
    ACT_CHECK  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_OWN,
    ST_SCAN,
    ST_LAST,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic wr;
    logic rd;
    logic rd_own;
    logic clr;
    logic fin;
    logic fin_zero;
  } cmd_t;

endpackage

// ===== rtl/lowest_timestamp_safety_check.sv =====
// ----------------------------------------------------------------------------
// lowest_timestamp_safety_check
// Keeps running and sending times per core and decides whether a core holds
// the lowest timestamp among the active cores.
// ----------------------------------------------------------------------------
// A transaction is taken when start_i is high and busy_o is low. Its result
// shows on safe_o and min_updates_o for exactly one cycle with done_o high;
// the receiver cannot stall it. A start or commit writes the tables in the
// state after accept and then registers its result. A check reads the
// checker's own time, then scans N cores, where N is the active core count
// limited to MAX_CORES: the time tables have one read port, so the scan reads
// one core per cycle; the last read is registered, then the result is formed
// and registered. An item with a core id beyond the tables or a spare action
// code gives a zero result in the cycle after accept. The next transaction
// may be taken in the cycle its predecessor's result is shown. active_cores
// may be written only while idle.
module lowest_timestamp_safety_check #(
  parameter int unsigned MAX_CORES = lts_pkg::DefMaxCores
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  action_i,
  input  logic [lts_pkg::CoreIdW-1:0] core_id_i,
  input  logic [lts_pkg::TimeW-1:0]   time_value_i,
  input  logic                        cfg_we_i,
  input  logic [lts_pkg::ActiveW-1:0] cfg_wdata_i,
  output logic                        done_o,
  output logic                        safe_o,
  output logic [lts_pkg::UpdW-1:0]    min_updates_o
);
  import lts_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_CORES);

  cmd_t            cmd;
  logic [IdxW-1:0] scan_idx;

  lts_ctrl #(
    .MAX_CORES (MAX_CORES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .action_i    (action_i),
    .core_id_i   (core_id_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .busy_o      (busy_o),
    .cmd_o       (cmd),
    .scan_idx_o  (scan_idx)
  );

  lts_dp #(
    .MAX_CORES (MAX_CORES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .scan_idx_i    (scan_idx),
    .action_i      (action_i),
    .core_id_i     (core_id_i),
    .time_value_i  (time_value_i),
    .done_o        (done_o),
    .safe_o        (safe_o),
    .min_updates_o (min_updates_o)
  );

endmodule

// ===== rtl/lts_ctrl.sv =====
// ----------------------------------------------------------------------------
// lts_ctrl
// Sequencer: decodes transactions, walks the core tables during a check and
// holds the active core count register.
// ----------------------------------------------------------------------------
module lts_ctrl #(
  parameter int unsigned MAX_CORES = lts_pkg::DefMaxCores,
  parameter int unsigned IdxW = $clog2(MAX_CORES),
  parameter int unsigned CntW = $clog2(MAX_CORES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [1:0]                  action_i,
  input  logic [lts_pkg::CoreIdW-1:0] core_id_i,
  input  logic                        cfg_we_i,
  input  logic [lts_pkg::ActiveW-1:0] cfg_wdata_i,
  output logic                        busy_o,
  output lts_pkg::cmd_t               cmd_o,
  output logic [IdxW-1:0]             scan_idx_o
);
  import lts_pkg::*;

  state_e              state_q, state_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [ActiveW-1:0]  active_q;
  logic [CntW-1:0]     cnt;
  logic                in_rng;
  logic                is_wr;
  logic                is_chk;

  assign in_rng = 32'(core_id_i) < MAX_CORES;
  assign is_wr  = (action_i == ACT_START) || (action_i == ACT_COMMIT);
  assign is_chk = action_i == ACT_CHECK;
  assign cnt    = (32'(active_q) > MAX_CORES) ? CntW'(MAX_CORES) : CntW'(active_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      active_q <= ACTIVE_RST;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (is_wr && in_rng) begin
            state_d = ST_WRITE;
          end else if (is_chk && in_rng) begin
            state_d = ST_OWN;
          end else begin
            cmd_o.fin      = 1'b1;
            cmd_o.fin_zero = 1'b1;
          end
        end
      end
      ST_WRITE: begin
        cmd_o.wr       = 1'b1;
        cmd_o.fin      = 1'b1;
        cmd_o.fin_zero = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_OWN: begin
        cmd_o.rd     = 1'b1;
        cmd_o.rd_own = 1'b1;
        cmd_o.clr    = 1'b1;
        idx_d        = '0;
        state_d      = (cnt == '0) ? ST_LAST : ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.rd = 1'b1;
        idx_d    = idx_q + 1'b1;
        if (CntW'(idx_q) + 1'b1 == cnt) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o     = state_q != ST_IDLE;
  assign scan_idx_o = idx_q;

endmodule

// ===== rtl/lts_dp.sv =====
// ----------------------------------------------------------------------------
// lts_dp
// Datapath: running and sending time tables, running minimum and result
// registers.
// ----------------------------------------------------------------------------
module lts_dp #(
  parameter int unsigned MAX_CORES = lts_pkg::DefMaxCores,
  parameter int unsigned IdxW = $clog2(MAX_CORES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lts_pkg::cmd_t               cmd_i,
  input  logic [IdxW-1:0]             scan_idx_i,
  input  logic [1:0]                  action_i,
  input  logic [lts_pkg::CoreIdW-1:0] core_id_i,
  input  logic [lts_pkg::TimeW-1:0]   time_value_i,
  output logic                        done_o,
  output logic                        safe_o,
  output logic [lts_pkg::UpdW-1:0]    min_updates_o
);
  import lts_pkg::*;

  logic [TimeW-1:0]     run_mem [MAX_CORES];
  logic [TimeW-1:0]     snd_mem [MAX_CORES];
  logic [MAX_CORES-1:0] vld_q;

  logic                 start_q;
  logic [IdxW-1:0]      core_q;
  logic [TimeW-1:0]     time_q;

  logic [IdxW-1:0]      rd_addr;
  logic [TimeW-1:0]     run_rd_q, snd_rd_q;
  logic                 hit_q;
  logic                 rd_vld_q, rd_own_q;
  logic [IdxW-1:0]      rd_idx_q;
  logic [TimeW-1:0]     r_eff, s_eff;

  logic [TimeW-1:0]     min_q, own_q;
  logic [IdxW-1:0]      min_core_q;
  logic                 have_q;
  logic [UpdW-1:0]      upd_q;
  logic                 lower;
  logic                 safe_c;

  logic                 done_q, safe_q;
  logic [UpdW-1:0]      upd_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      start_q <= action_i == ACT_START;
      core_q  <= IdxW'(core_id_i);
      time_q  <= time_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      run_mem[core_q] <= start_q ? time_q : TIME_INF;
      snd_mem[core_q] <= start_q ? TIME_INF : time_q;
    end
    run_rd_q <= run_mem[rd_addr];
    snd_rd_q <= snd_mem[rd_addr];
    rd_idx_q <= rd_addr;
  end

  assign rd_addr = cmd_i.rd_own ? core_q : scan_idx_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      hit_q    <= 1'b0;
      rd_vld_q <= 1'b0;
      rd_own_q <= 1'b0;
    end else begin
      if (cmd_i.wr) begin
        vld_q[core_q] <= 1'b1;
      end
      hit_q    <= vld_q[rd_addr];
      rd_vld_q <= cmd_i.rd;
      rd_own_q <= cmd_i.rd_own;
    end
  end

  assign r_eff = hit_q ? run_rd_q : TIME_INF;
  assign s_eff = hit_q ? snd_rd_q : TIME_INF;
  assign lower = (r_eff < min_q) || (s_eff < min_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q      <= TIME_INF;
      own_q      <= TIME_INF;
      min_core_q <= '0;
      have_q     <= 1'b0;
      upd_q      <= '0;
    end else if (cmd_i.clr) begin
      min_q      <= TIME_INF;
      min_core_q <= '0;
      have_q     <= 1'b0;
      upd_q      <= '0;
    end else if (rd_vld_q) begin
      if (rd_own_q) begin
        own_q <= r_eff;
      end else if ((rd_idx_q != core_q) && lower) begin
        min_q      <= (r_eff < s_eff) ? r_eff : s_eff;
        min_core_q <= rd_idx_q;
        have_q     <= 1'b1;
        if (upd_q != UPD_MAX) begin
          upd_q <= upd_q + 1'b1;
        end
      end
    end
  end

  assign safe_c = (own_q < min_q) ||
                  ((own_q == min_q) && (!have_q || (core_q < min_core_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      safe_q    <= cmd_i.fin_zero ? 1'b0 : safe_c;
      upd_out_q <= cmd_i.fin_zero ? '0 : upd_q;
    end
  end

  assign done_o        = done_q;
  assign safe_o        = safe_q;
  assign min_updates_o = upd_out_q;

endmodule

// ===== rtl/lts_checker.sv =====
// ----------------------------------------------------------------------------
// lts_checker
// Port-level checks of the lowest-timestamp safety check, bound to the top.
// ----------------------------------------------------------------------------
module lts_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic [1:0]                  action_i,
  input logic                        done_o,
  input logic                        safe_o,
  input logic [lts_pkg::UpdW-1:0]    min_updates_o
);
  import lts_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("work ended without a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (action_i == ACT_START || action_i == ACT_COMMIT))
      |=> (busy_o || (done_o && !safe_o && min_updates_o == '0)))
    else $error("table update lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (safe_o || min_updates_o != '0)) |-> $past(busy_o))
    else $error("check result without a scan");

endmodule

bind lowest_timestamp_safety_check lts_checker u_lts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .action_i      (action_i),
  .done_o        (done_o),
  .safe_o        (safe_o),
  .min_updates_o (min_updates_o)
);
